@@ src/bdc_pkg.sv @@
// Shared types and constants for the button debounce / combo controller.
// No dependencies; used by every module in src.
package bdc_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int PIN_W  = 6;
  localparam int TS_W   = 32;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_BUTTON_A_PIN = 3'd0;
  localparam logic [2:0] REG_BUTTON_B_PIN = 3'd1;
  localparam logic [2:0] REG_LINE_A_PIN   = 3'd2;
  localparam logic [2:0] REG_LINE_B_PIN   = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE     = 3'd4;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd5;
  localparam logic [2:0] REG_SETTLE       = 3'd6;
  localparam logic [2:0] REG_HOLD         = 3'd7;

  // request types
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // toggle sources
  localparam logic [1:0] SRC_BUTTON_A = 2'd0;
  localparam logic [1:0] SRC_BUTTON_B = 2'd1;
  localparam logic [1:0] SRC_LINE_A   = 2'd2;
  localparam logic [1:0] SRC_LINE_B   = 2'd3;

  typedef struct packed {
    logic [PIN_W-1:0] button_a_pin;
    logic [PIN_W-1:0] button_b_pin;
    logic [PIN_W-1:0] line_a_pin;
    logic [PIN_W-1:0] line_b_pin;
    logic [15:0]      debounce_ticks;
    logic [15:0]      long_press_ticks;
    logic [15:0]      settle_ticks;
    logic [23:0]      hold_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    button_a_pin:     6'd0,
    button_b_pin:     6'd1,
    line_a_pin:       6'd2,
    line_b_pin:       6'd3,
    debounce_ticks:   16'd5,
    long_press_ticks: 16'd100,
    settle_ticks:     16'd10,
    hold_ticks:       24'd1000
  };

  typedef struct packed {
    logic             req_type;
    logic [PIN_W-1:0] pin_number;
    logic             pin_level;
    logic [TS_W-1:0]  timestamp;
  } item_t;

  typedef struct packed {
    logic       toggle;
    logic [1:0] toggle_line;
    logic       combo_expired;
  } res_t;

endpackage

@@ src/bdc_cfg.sv @@
// APB-style configuration register file for the debounce / combo controller.
// Depends on bdc_pkg (cfg_t, register indexes, reset values).
module bdc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bdc_pkg::ADDR_W-1:0] paddr,
  input  logic [bdc_pkg::DATA_W-1:0] pwdata,
  output logic [bdc_pkg::DATA_W-1:0] prdata,
  output bdc_pkg::cfg_t              cfg
);

  bdc_pkg::cfg_t cfg_r;
  bdc_pkg::cfg_t cfg_nxt;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        bdc_pkg::REG_BUTTON_A_PIN: cfg_nxt.button_a_pin     = pwdata[5:0];
        bdc_pkg::REG_BUTTON_B_PIN: cfg_nxt.button_b_pin     = pwdata[5:0];
        bdc_pkg::REG_LINE_A_PIN:   cfg_nxt.line_a_pin       = pwdata[5:0];
        bdc_pkg::REG_LINE_B_PIN:   cfg_nxt.line_b_pin       = pwdata[5:0];
        bdc_pkg::REG_DEBOUNCE:     cfg_nxt.debounce_ticks   = pwdata[15:0];
        bdc_pkg::REG_LONG_PRESS:   cfg_nxt.long_press_ticks = pwdata[15:0];
        bdc_pkg::REG_SETTLE:       cfg_nxt.settle_ticks     = pwdata[15:0];
        bdc_pkg::REG_HOLD:         cfg_nxt.hold_ticks       = pwdata[23:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bdc_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      bdc_pkg::REG_BUTTON_A_PIN: prdata = 32'(cfg_r.button_a_pin);
      bdc_pkg::REG_BUTTON_B_PIN: prdata = 32'(cfg_r.button_b_pin);
      bdc_pkg::REG_LINE_A_PIN:   prdata = 32'(cfg_r.line_a_pin);
      bdc_pkg::REG_LINE_B_PIN:   prdata = 32'(cfg_r.line_b_pin);
      bdc_pkg::REG_DEBOUNCE:     prdata = 32'(cfg_r.debounce_ticks);
      bdc_pkg::REG_LONG_PRESS:   prdata = 32'(cfg_r.long_press_ticks);
      bdc_pkg::REG_SETTLE:       prdata = 32'(cfg_r.settle_ticks);
      bdc_pkg::REG_HOLD:         prdata = 32'(cfg_r.hold_ticks);
      default:                   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ src/bdc_step.sv @@
// Per-line debounce, press timing and combo hold state plus the one-item step logic.
// Depends on bdc_pkg (cfg_t, item_t, res_t, codes).
module bdc_step #(
  parameter int TIME_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  bdc_pkg::cfg_t  cfg,
  input  bdc_pkg::item_t item,
  output bdc_pkg::res_t  res
);

  // compare width wide enough for both the time diffs and the 24-bit hold limit
  localparam int CW = (TIME_BITS > 24) ? TIME_BITS : 24;

  typedef logic [TIME_BITS-1:0] tstamp_t;

  logic    pressed_r      [2];
  logic    pressed_nxt    [2];
  tstamp_t last_edge_r    [2];
  tstamp_t last_edge_nxt  [2];
  tstamp_t press_start_r  [2];
  tstamp_t press_start_nxt[2];
  logic    in_combo_r     [2];
  logic    in_combo_nxt   [2];
  tstamp_t line_last_r    [2];
  tstamp_t line_last_nxt  [2];
  logic    both_held_r, both_held_nxt;
  logic    armed_r, armed_nxt;
  tstamp_t reset_start_r, reset_start_nxt;

  tstamp_t ts;
  logic    hit_line_a, hit_line, hit_btn_a, hit_btn;
  logic    lidx, bidx;
  logic    pressed_now;
  tstamp_t line_diff, edge_diff, press_diff, hold_diff;
  logic    btn_pressed_sel, btn_other_pressed, btn_in_combo_sel;
  logic    line_settled, btn_edge_ok, short_press, hold_done;

  assign ts          = TIME_BITS'(item.timestamp);
  assign pressed_now = !item.pin_level;

  assign hit_line_a = (item.pin_number == cfg.line_a_pin);
  assign hit_line   = hit_line_a || (item.pin_number == cfg.line_b_pin);
  assign hit_btn_a  = (item.pin_number == cfg.button_a_pin);
  assign hit_btn    = hit_btn_a || (item.pin_number == cfg.button_b_pin);
  assign lidx       = !hit_line_a;
  assign bidx       = !hit_btn_a;

  assign btn_pressed_sel   = bidx ? pressed_r[1] : pressed_r[0];
  assign btn_other_pressed = bidx ? pressed_r[0] : pressed_r[1];
  assign btn_in_combo_sel  = bidx ? in_combo_r[1] : in_combo_r[0];

  assign line_diff  = ts - (lidx ? line_last_r[1] : line_last_r[0]);
  assign edge_diff  = ts - (bidx ? last_edge_r[1] : last_edge_r[0]);
  assign press_diff = ts - (bidx ? press_start_r[1] : press_start_r[0]);
  assign hold_diff  = ts - reset_start_r;

  assign line_settled = CW'(line_diff) >= CW'(cfg.settle_ticks);
  assign btn_edge_ok  = (pressed_now != btn_pressed_sel) &&
                        (CW'(edge_diff) >= CW'(cfg.debounce_ticks));
  assign short_press  = CW'(press_diff) < CW'(cfg.long_press_ticks);
  assign hold_done    = CW'(hold_diff) >= CW'(cfg.hold_ticks);

  always_comb begin
    pressed_nxt     = pressed_r;
    last_edge_nxt   = last_edge_r;
    press_start_nxt = press_start_r;
    in_combo_nxt    = in_combo_r;
    line_last_nxt   = line_last_r;
    both_held_nxt   = both_held_r;
    armed_nxt       = armed_r;
    reset_start_nxt = reset_start_r;
    res             = '0;

    if (item.req_type == bdc_pkg::REQ_TICK) begin
      if (armed_r && hold_done) begin
        res.combo_expired = 1'b1;
        armed_nxt         = 1'b0;
      end
    end else if (hit_line) begin
      if (line_settled) begin
        res.toggle      = 1'b1;
        res.toggle_line = lidx ? bdc_pkg::SRC_LINE_B : bdc_pkg::SRC_LINE_A;
      end
      line_last_nxt[lidx] = ts;
    end else if (hit_btn && btn_edge_ok) begin
      pressed_nxt[bidx]   = pressed_now;
      last_edge_nxt[bidx] = ts;
      if (pressed_now) begin
        press_start_nxt[bidx] = ts;
        // this press completes the combo when the other button is still down
        if (btn_other_pressed) begin
          both_held_nxt   = 1'b1;
          in_combo_nxt[0] = 1'b1;
          in_combo_nxt[1] = 1'b1;
          armed_nxt       = 1'b1;
          reset_start_nxt = ts;
        end
      end else begin
        if (both_held_r) begin
          both_held_nxt = 1'b0;
          armed_nxt     = 1'b0;
        end
        in_combo_nxt[bidx] = 1'b0;
        if (!btn_in_combo_sel && short_press) begin
          res.toggle      = 1'b1;
          res.toggle_line = bidx ? bdc_pkg::SRC_BUTTON_B : bdc_pkg::SRC_BUTTON_A;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r     <= '{default: 1'b0};
      last_edge_r   <= '{default: '0};
      press_start_r <= '{default: '0};
      in_combo_r    <= '{default: 1'b0};
      line_last_r   <= '{default: '0};
      both_held_r   <= 1'b0;
      armed_r       <= 1'b0;
      reset_start_r <= '0;
    end else if (step_en) begin
      pressed_r     <= pressed_nxt;
      last_edge_r   <= last_edge_nxt;
      press_start_r <= press_start_nxt;
      in_combo_r    <= in_combo_nxt;
      line_last_r   <= line_last_nxt;
      both_held_r   <= both_held_nxt;
      armed_r       <= armed_nxt;
      reset_start_r <= reset_start_nxt;
    end
  end

endmodule

@@ src/button_debounce_combo_controller.sv @@
// Button debounce / combo controller: input register, combinational step, result register.
// A beat passes the input register, then the result register; throughput is one beat
// per cycle while out_ready is high, set by the step logic between the registers.
// Reset (rst_n low, synchronous): pipeline empty, per-line state zero, registers
// at their defaults. Depends on bdc_pkg, bdc_cfg, bdc_step.
module button_debounce_combo_controller #(
  parameter int TIME_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [5:0]                 in_pin_number,
  input  logic                       in_pin_level,
  input  logic [31:0]                in_timestamp,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_toggle,
  output logic [1:0]                 out_toggle_line,
  output logic                       out_combo_expired,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [bdc_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [bdc_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [bdc_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  bdc_pkg::cfg_t  cfg;
  bdc_pkg::item_t item_r;
  bdc_pkg::res_t  step_res;
  bdc_pkg::res_t  res_r;
  logic           item_valid_r;
  logic           out_valid_r;
  logic           advance;
  logic           in_fire;

  assign cfg_pready = 1'b1;

  bdc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // result register free or draining this cycle
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !item_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  bdc_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (item_valid_r && advance),
    .cfg     (cfg),
    .item    (item_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= item_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.req_type   <= in_req_type;
      item_r.pin_number <= in_pin_number;
      item_r.pin_level  <= in_pin_level;
      item_r.timestamp  <= in_timestamp;
    end
    if (advance && item_valid_r) begin
      res_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_toggle        = res_r.toggle;
  assign out_toggle_line   = res_r.toggle_line;
  assign out_combo_expired = res_r.combo_expired;

endmodule
